>>> src/hot_block_profile_table_top_assert.svh
// Assertion macros for the hot block profile table.
// Used by hot_block_profile_table_top; needs clk_i and rst_ni in scope.
`ifndef HOT_BLOCK_PROFILE_TABLE_TOP_ASSERT_SVH
`define HOT_BLOCK_PROFILE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define HBPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HBPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HBPT_ASSERT(lbl, prop, msg)
`define HBPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/hbpt_pkg.sv
// Shared types and constants for the hot block profile table.
// No dependencies.
package hbpt_pkg;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_MARK   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_HOT_THR   = 2'd0,
    CFG_AGGR_THR  = 2'd1,
    CFG_CONSEC    = 2'd2,
    CFG_THROTTLE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_RDREC, S_UPD, S_DIVST, S_DIVW, S_FIN
  } state_e;

  localparam logic [1:0] TIER_FAST   = 2'd0;
  localparam logic [1:0] TIER_NORMAL = 2'd1;
  localparam logic [1:0] TIER_HOT    = 2'd2;

  localparam logic [1:0] PRIO_LOW      = 2'd0;
  localparam logic [1:0] PRIO_NORMAL   = 2'd1;
  localparam logic [1:0] PRIO_HIGH     = 2'd2;
  localparam logic [1:0] PRIO_CRITICAL = 2'd3;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // Per-entry profile record as held in the statistics memory.
  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] avg;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] hh;
    logic [1:0]  tier;
    logic        hot;
    logic        rcf;
  } rec_t;

endpackage

>>> src/hbpt_mem.sv
// Simple dual-port memory with registered read, for addresses and records.
// No dependencies.
module hbpt_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/hbpt_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// No dependencies; the quotient is known to fit in 32 bits.
module hbpt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  // One shift-and-subtract step per cycle.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], num_q[63]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (start_i) begin
      num_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 7'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[33]) begin
        rem_d = diff[32:0];
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q[31:0];
endmodule

>>> src/hot_block_profile_table_top.sv
// Top level of the hot block profile table: sequencer, global counters, outputs.
// Depends on hbpt_pkg, hbpt_mem, hbpt_div and the assertion header.
//
// Usage: a command is taken at a clock edge where start_i is high and busy_o
// is low. The sequencer then walks the allocated entries one per cycle through
// the address memory port, allocates a new entry if a record or mark misses
// and the table has room, reads the entry's record, updates it, and for a
// record on an entry that already has a count runs the running average
// through a bit-serial divider. The result appears on the result ports for
// one cycle with done_o high; the receiver cannot stall. The entry search
// and, for such a record, the divider set how long a command takes. busy_o
// stays high for the whole transaction, so one command is worked at a time.
// Configuration writes use cfg_valid_i/cfg_ready_o and are taken at once;
// they are to be issued by the user only while the block is idle; the block
// itself does not enforce this.
// Reset clears the allocation count, the global counters and the
// configuration registers to their defaults; no memory clearing is needed.
module hot_block_profile_table_top #(
  parameter int ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] block_address_i,
  input  logic [31:0] exec_time_ns_i,
  input  logic        hot_cache_at_limit_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic        entry_found_o,
  output logic        table_full_o,
  output logic [1:0]  opt_tier_o,
  output logic        should_recompile_o,
  output logic [1:0]  priority_res_o,
  output logic [31:0] exec_count_o,
  output logic [31:0] avg_time_o,
  output logic [31:0] min_time_o,
  output logic [31:0] max_time_o,
  output logic [63:0] total_exec_count_o,
  output logic [63:0] hot_exec_count_o,
  output logic [31:0] recompile_marks_o
);
  localparam int AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] FULL = IW'(ENTRIES);
  localparam int RW = $bits(hbpt_pkg::rec_t);

  hbpt_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] hot_thr_q, aggr_thr_q, consec_q;
  logic        throttle_q;

  // Command latches and sequencer registers.
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [31:0] t_q;
  logic        lim_q;
  logic [IW-1:0] idx_q, idx_d, used_q, used_d, cidx_q, cidx_d, k_q, k_d;
  logic        cmp_v_q, cmp_v_d, fresh_q, fresh_d, has_q, has_d;
  logic [63:0] tot_q, tot_d, hotx_q, hotx_d;
  logic [31:0] marks_q, marks_d;
  hbpt_pkg::rec_t rec_q, rec_d, base;
  logic [63:0] prod_q, prod_d;
  logic        is_alloc_op, match;

  // Memories and divider.
  logic [63:0]   addr_rd;
  logic [RW-1:0] stat_rd;
  logic          a_we, s_we;
  logic [AW-1:0] s_raddr;
  logic          div_done;
  logic [31:0]   div_q;

  hbpt_mem #(.DEPTH(ENTRIES), .WIDTH(64)) u_addr_mem (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(used_q[AW-1:0]),
    .wdata_i(key_q),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(addr_rd)
  );

  hbpt_mem #(.DEPTH(ENTRIES), .WIDTH(RW)) u_stat_mem (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(k_q[AW-1:0]),
    .wdata_i(rec_q),
    .raddr_i(s_raddr),
    .rdata_o(stat_rd)
  );

  hbpt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == hbpt_pkg::S_DIVST),
    .dividend_i(prod_q + {32'd0, t_q}),
    .divisor_i (rec_q.cnt),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  assign is_alloc_op = (op_q == hbpt_pkg::OP_RECORD) || (op_q == hbpt_pkg::OP_MARK);
  assign match       = cmp_v_q && (addr_rd == key_q);
  assign base        = fresh_q ? hbpt_pkg::rec_t'('0) : hbpt_pkg::rec_t'(stat_rd);
  assign s_raddr     = k_q[AW-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hbpt_pkg::S_IDLE:   if (start_i) state_d = hbpt_pkg::S_SEARCH;
      hbpt_pkg::S_SEARCH: begin
        if (match) begin
          state_d = hbpt_pkg::S_RDREC;
        end else if (!cmp_v_q && idx_q == used_q) begin
          if (is_alloc_op && used_q < FULL) state_d = hbpt_pkg::S_RDREC;
          else                              state_d = hbpt_pkg::S_FIN;
        end
      end
      hbpt_pkg::S_RDREC:  state_d = hbpt_pkg::S_UPD;
      hbpt_pkg::S_UPD: begin
        if (op_q == hbpt_pkg::OP_RECORD && base.cnt != 32'd0)
          state_d = hbpt_pkg::S_DIVST;
        else
          state_d = hbpt_pkg::S_FIN;
      end
      hbpt_pkg::S_DIVST:  state_d = hbpt_pkg::S_DIVW;
      hbpt_pkg::S_DIVW:   if (div_done) state_d = hbpt_pkg::S_FIN;
      hbpt_pkg::S_FIN:    state_d = hbpt_pkg::S_IDLE;
      default:            state_d = hbpt_pkg::S_IDLE;
    endcase
  end

  // Datapath and control outputs of the sequencer.
  always_comb begin
    logic [31:0] n, hh_n;
    idx_d   = idx_q;
    cidx_d  = cidx_q;
    cmp_v_d = cmp_v_q;
    k_d     = k_q;
    fresh_d = fresh_q;
    has_d   = has_q;
    used_d  = used_q;
    tot_d   = tot_q;
    hotx_d  = hotx_q;
    marks_d = marks_q;
    rec_d   = rec_q;
    prod_d  = prod_q;
    a_we    = 1'b0;
    s_we    = 1'b0;
    n       = '0;
    hh_n    = '0;
    unique case (state_q)
      hbpt_pkg::S_IDLE: begin
        idx_d   = '0;
        cmp_v_d = 1'b0;
        has_d   = 1'b0;
      end
      hbpt_pkg::S_SEARCH: begin
        if (match) begin
          k_d     = cidx_q;
          fresh_d = 1'b0;
          has_d   = 1'b1;
        end else if (!cmp_v_q && idx_q == used_q) begin
          if (is_alloc_op && used_q < FULL) begin
            a_we    = 1'b1;
            k_d     = used_q;
            used_d  = used_q + IW'(1);
            fresh_d = 1'b1;
            has_d   = 1'b1;
          end
        end else if (idx_q < used_q) begin
          cidx_d  = idx_q;
          idx_d   = idx_q + IW'(1);
          cmp_v_d = 1'b1;
        end else begin
          cmp_v_d = 1'b0;
        end
      end
      hbpt_pkg::S_UPD: begin
        rec_d = base;
        if (op_q == hbpt_pkg::OP_RECORD) begin
          n = (base.cnt == hbpt_pkg::MAX32) ? base.cnt : base.cnt + 32'd1;
          rec_d.cnt = n;
          if (tot_q != hbpt_pkg::MAX64) tot_d = tot_q + 64'd1;
          if (n == 32'd1) begin
            rec_d.avg = t_q;
            rec_d.mn  = t_q;
            rec_d.mx  = t_q;
          end else begin
            if (t_q < base.mn) rec_d.mn = t_q;
            if (t_q > base.mx) rec_d.mx = t_q;
          end
          prod_d = 64'(base.avg) * 64'(n - 32'd1);
          if (n >= hot_thr_q) begin
            hh_n      = (base.hh == hbpt_pkg::MAX32) ? base.hh : base.hh + 32'd1;
            rec_d.hot = 1'b1;
            rec_d.hh  = hh_n;
            if (hotx_q != hbpt_pkg::MAX64) hotx_d = hotx_q + 64'd1;
            if (base.tier < hbpt_pkg::TIER_HOT) begin
              if (n >= aggr_thr_q) begin
                if (hh_n >= consec_q) begin
                  rec_d.rcf  = 1'b1;
                  rec_d.tier = hbpt_pkg::TIER_HOT;
                end
              end else if (hh_n >= 32'd2 && base.tier < hbpt_pkg::TIER_NORMAL) begin
                rec_d.tier = hbpt_pkg::TIER_NORMAL;
                rec_d.rcf  = 1'b1;
              end
            end
          end
        end else if (op_q == hbpt_pkg::OP_MARK) begin
          rec_d.rcf = 1'b1;
          if (marks_q != hbpt_pkg::MAX32) marks_d = marks_q + 32'd1;
        end
      end
      hbpt_pkg::S_DIVW: begin
        if (div_done) rec_d.avg = div_q;
      end
      hbpt_pkg::S_FIN: begin
        s_we = has_q;
      end
      default: begin
      end
    endcase
  end

  // Result fields formed from the final record.
  logic [40:0] score;
  logic [1:0]  prio;
  always_comb begin
    score = 41'(rec_q.cnt) * 41'd10 + 41'(rec_q.hh) * 41'd100
          + ((rec_q.tier >= hbpt_pkg::TIER_HOT) ? 41'd500 : 41'd0);
    if (score > 41'd5000 || (rec_q.hot && rec_q.cnt > 32'd10000))
      prio = hbpt_pkg::PRIO_CRITICAL;
    else if (score > 41'd1000 || rec_q.hot)
      prio = hbpt_pkg::PRIO_HIGH;
    else if (rec_q.cnt < 32'd50)
      prio = hbpt_pkg::PRIO_LOW;
    else
      prio = hbpt_pkg::PRIO_NORMAL;
  end

  // Control registers, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hbpt_pkg::S_IDLE;
      used_q     <= '0;
      tot_q      <= '0;
      hotx_q     <= '0;
      marks_q    <= '0;
      idx_q      <= '0;
      cidx_q     <= '0;
      cmp_v_q    <= 1'b0;
      k_q        <= '0;
      fresh_q    <= 1'b0;
      has_q      <= 1'b0;
      done_o     <= 1'b0;
      hot_thr_q  <= 32'd100;
      aggr_thr_q <= 32'd1000;
      consec_q   <= 32'd3;
      throttle_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      tot_q   <= tot_d;
      hotx_q  <= hotx_d;
      marks_q <= marks_d;
      idx_q   <= idx_d;
      cidx_q  <= cidx_d;
      cmp_v_q <= cmp_v_d;
      k_q     <= k_d;
      fresh_q <= fresh_d;
      has_q   <= has_d;
      done_o  <= (state_q == hbpt_pkg::S_FIN);
      if (cfg_valid_i) begin
        unique case (hbpt_pkg::cfg_idx_e'(cfg_index_i))
          hbpt_pkg::CFG_HOT_THR:  hot_thr_q  <= cfg_data_i;
          hbpt_pkg::CFG_AGGR_THR: aggr_thr_q <= cfg_data_i;
          hbpt_pkg::CFG_CONSEC:   consec_q   <= cfg_data_i;
          hbpt_pkg::CFG_THROTTLE: throttle_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: command latch, working record and result.
  always_ff @(posedge clk_i) begin
    if (state_q == hbpt_pkg::S_IDLE && start_i) begin
      op_q  <= op_i;
      key_q <= block_address_i;
      t_q   <= exec_time_ns_i;
      lim_q <= hot_cache_at_limit_i;
    end
    rec_q  <= rec_d;
    prod_q <= prod_d;
    if (state_q == hbpt_pkg::S_FIN) begin
      entry_found_o      <= has_q;
      table_full_o       <= !has_q && is_alloc_op;
      opt_tier_o         <= has_q ? rec_q.tier : hbpt_pkg::TIER_FAST;
      should_recompile_o <= has_q && !throttle_q && rec_q.rcf &&
                            (!lim_q || rec_q.tier >= hbpt_pkg::TIER_HOT);
      priority_res_o     <= has_q ? prio : hbpt_pkg::PRIO_NORMAL;
      exec_count_o       <= has_q ? rec_q.cnt : 32'd0;
      avg_time_o         <= has_q ? rec_q.avg : 32'd0;
      min_time_o         <= has_q ? rec_q.mn : 32'd0;
      max_time_o         <= has_q ? rec_q.mx : 32'd0;
      total_exec_count_o <= tot_q;
      hot_exec_count_o   <= hotx_q;
      recompile_marks_o  <= marks_q;
    end
  end

  assign busy_o      = (state_q != hbpt_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

`include "hot_block_profile_table_top_assert.svh"

  `HBPT_ASSERT(a_used_bound, used_q <= FULL, "allocation count beyond table size")
  `HBPT_ASSERT(a_done_after_fin, done_o |-> $past(state_q == hbpt_pkg::S_FIN), "stray done")
  `HBPT_ASSERT(a_start_busy, (start_i && !busy_o) |=> busy_o, "command not taken")
  `HBPT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !busy_o, "busy during reset")
endmodule

>>> sim/hot_block_profile_table_top_test.sv
// Self-checking testbench for hot_block_profile_table_top.
// Needs hbpt_pkg and the RTL of the block; predicts each result and compares on done_o.
module hot_block_profile_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 256;
  localparam int POOL = 320;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [63:0] block_address_i;
  logic [31:0] exec_time_ns_i;
  logic        hot_cache_at_limit_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        done_o;
  logic        entry_found_o;
  logic        table_full_o;
  logic [1:0]  opt_tier_o;
  logic        should_recompile_o;
  logic [1:0]  priority_res_o;
  logic [31:0] exec_count_o;
  logic [31:0] avg_time_o;
  logic [31:0] min_time_o;
  logic [31:0] max_time_o;
  logic [63:0] total_exec_count_o;
  logic [63:0] hot_exec_count_o;
  logic [31:0] recompile_marks_o;

  hot_block_profile_table_top #(.ENTRIES(ENTRIES)) i_dut (.*);

  // One profile answer as the block reports it.
  typedef struct {
    logic        found;
    logic        full;
    logic [1:0]  tier;
    logic        recompile;
    logic [1:0]  prio;
    logic [31:0] cnt;
    logic [31:0] avg;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [63:0] total;
    logic [63:0] hot_total;
    logic [31:0] marks;
  } profile_t;

  profile_t pending_profiles[$];
  int unsigned error_count = 0;

  // Shadow copy of the block's configuration and table.
  logic [31:0] hot_thr_q, aggr_thr_q, consec_q;
  logic        throttle_q;
  logic [63:0] tab_addr[ENTRIES];
  logic [31:0] tab_cnt[ENTRIES], tab_avg[ENTRIES], tab_mn[ENTRIES], tab_mx[ENTRIES];
  logic [31:0] tab_hh[ENTRIES];
  logic [1:0]  tab_tier[ENTRIES];
  logic        tab_hot[ENTRIES], tab_rcf[ENTRIES];
  int          used_q;
  logic [63:0] total_q, hot_total_q;
  logic [31:0] marks_q;
  logic [63:0] addr_pool[POOL];

  // Clock; reset is driven by the stimulus sequence.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung block.
  initial begin
    #40ms;
    $display("hot_block_profile_table_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  // Works out the answer for one command and updates the shadow table.
  function automatic profile_t profile_predict(hbpt_pkg::op_e op, logic [63:0] addr,
                                               logic [31:0] t, logic lim);
    profile_t r;
    int k;
    logic [31:0] n;
    logic [63:0] sum, score;
    logic alloc_op;
    alloc_op = (op == hbpt_pkg::OP_RECORD || op == hbpt_pkg::OP_MARK);
    k = -1;
    for (int i = 0; i < used_q; i++)
      if (k < 0 && tab_addr[i] == addr) k = i;
    if (k < 0 && alloc_op && used_q < ENTRIES) begin
      k = used_q;
      tab_addr[k] = addr;
      tab_cnt[k] = '0; tab_avg[k] = '0; tab_mn[k] = '0; tab_mx[k] = '0;
      tab_hh[k] = '0; tab_tier[k] = hbpt_pkg::TIER_FAST;
      tab_hot[k] = 1'b0; tab_rcf[k] = 1'b0;
      used_q++;
    end
    if (k >= 0 && op == hbpt_pkg::OP_RECORD) begin
      if (tab_cnt[k] != hbpt_pkg::MAX32) tab_cnt[k]++;
      n = tab_cnt[k];
      if (total_q != hbpt_pkg::MAX64) total_q++;
      if (n == 1) begin
        tab_avg[k] = t; tab_mn[k] = t; tab_mx[k] = t;
      end else begin
        sum = 64'(tab_avg[k]) * 64'(n - 1) + 64'(t);
        tab_avg[k] = 32'(sum / 64'(n));
        if (t < tab_mn[k]) tab_mn[k] = t;
        if (t > tab_mx[k]) tab_mx[k] = t;
      end
      if (n >= hot_thr_q) begin
        tab_hot[k] = 1'b1;
        if (tab_hh[k] != hbpt_pkg::MAX32) tab_hh[k]++;
        if (hot_total_q != hbpt_pkg::MAX64) hot_total_q++;
        if (tab_tier[k] < hbpt_pkg::TIER_HOT) begin
          if (n >= aggr_thr_q) begin
            if (tab_hh[k] >= consec_q) begin
              tab_rcf[k] = 1'b1;
              tab_tier[k] = hbpt_pkg::TIER_HOT;
            end
          end else if (tab_hh[k] >= 2 && tab_tier[k] < hbpt_pkg::TIER_NORMAL) begin
            tab_tier[k] = hbpt_pkg::TIER_NORMAL;
            tab_rcf[k] = 1'b1;
          end
        end
      end
    end else if (k >= 0 && op == hbpt_pkg::OP_MARK) begin
      tab_rcf[k] = 1'b1;
      if (marks_q != hbpt_pkg::MAX32) marks_q++;
    end
    r.found = 1'b0;
    r.full = (k < 0 && alloc_op);
    r.tier = hbpt_pkg::TIER_FAST;
    r.recompile = 1'b0;
    r.prio = hbpt_pkg::PRIO_NORMAL;
    r.cnt = '0; r.avg = '0; r.mn = '0; r.mx = '0;
    if (k >= 0) begin
      r.found = 1'b1;
      r.tier = tab_tier[k];
      r.recompile = !throttle_q && tab_rcf[k] &&
                    (!lim || tab_tier[k] >= hbpt_pkg::TIER_HOT);
      score = 64'(tab_cnt[k]) * 10 + 64'(tab_hh[k]) * 100;
      if (tab_tier[k] >= hbpt_pkg::TIER_HOT) score += 500;
      if (score > 5000 || (tab_hot[k] && tab_cnt[k] > 10000))
        r.prio = hbpt_pkg::PRIO_CRITICAL;
      else if (score > 1000 || tab_hot[k]) r.prio = hbpt_pkg::PRIO_HIGH;
      else if (tab_cnt[k] < 50) r.prio = hbpt_pkg::PRIO_LOW;
      else r.prio = hbpt_pkg::PRIO_NORMAL;
      r.cnt = tab_cnt[k]; r.avg = tab_avg[k]; r.mn = tab_mn[k]; r.mx = tab_mx[k];
    end
    r.total = total_q;
    r.hot_total = hot_total_q;
    r.marks = marks_q;
    return r;
  endfunction

  // Result checker: every done_o pulse is compared with the oldest expectation.
  always @(posedge clk_i) begin
    profile_t w;
    if (rst_ni && done_o) begin
      if (pending_profiles.size() == 0) begin
        error_count++;
        $display("%0t: result with no command outstanding", $realtime);
      end else begin
        w = pending_profiles.pop_front();
        if (entry_found_o !== w.found) report_mismatch("entry_found", entry_found_o, w.found);
        if (table_full_o !== w.full) report_mismatch("table_full", table_full_o, w.full);
        if (opt_tier_o !== w.tier) report_mismatch("opt_tier", opt_tier_o, w.tier);
        if (should_recompile_o !== w.recompile)
          report_mismatch("should_recompile", should_recompile_o, w.recompile);
        if (priority_res_o !== w.prio) report_mismatch("priority", priority_res_o, w.prio);
        if (exec_count_o !== w.cnt) report_mismatch("exec_count", exec_count_o, w.cnt);
        if (avg_time_o !== w.avg) report_mismatch("avg_time", avg_time_o, w.avg);
        if (min_time_o !== w.mn) report_mismatch("min_time", min_time_o, w.mn);
        if (max_time_o !== w.mx) report_mismatch("max_time", max_time_o, w.mx);
        if (total_exec_count_o !== w.total)
          report_mismatch("total_exec_count", total_exec_count_o, w.total);
        if (hot_exec_count_o !== w.hot_total)
          report_mismatch("hot_exec_count", hot_exec_count_o, w.hot_total);
        if (recompile_marks_o !== w.marks)
          report_mismatch("recompile_marks", recompile_marks_o, w.marks);
      end
    end
  end

  // Sends one command, after an optional idle gap, and records its expectation.
  task automatic send_command(hbpt_pkg::op_e op, logic [63:0] addr, logic [31:0] t,
                              logic lim, int idle_pct);
    if ($urandom_range(99) < idle_pct)
      repeat ($urandom_range(1, 120)) @(posedge clk_i);
    @(posedge clk_i);
    start_i <= 1'b1;
    op_i <= op;
    block_address_i <= addr;
    exec_time_ns_i <= t;
    hot_cache_at_limit_i <= lim;
    do @(posedge clk_i); while (busy_o);
    pending_profiles.push_back(profile_predict(op, addr, t, lim));
    start_i <= 1'b0;
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_config(hbpt_pkg::cfg_idx_e idx, logic [31:0] data);
    while (pending_profiles.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hbpt_pkg::CFG_HOT_THR:  hot_thr_q = data;
      hbpt_pkg::CFG_AGGR_THR: aggr_thr_q = data;
      hbpt_pkg::CFG_CONSEC:   consec_q = data;
      default:                throttle_q = data[0];
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_thresholds(logic [31:0] hot_thr, logic [31:0] aggr_thr,
                                logic [31:0] consec, logic throttle);
    write_config(hbpt_pkg::CFG_HOT_THR, hot_thr);
    write_config(hbpt_pkg::CFG_AGGR_THR, aggr_thr);
    write_config(hbpt_pkg::CFG_CONSEC, consec);
    write_config(hbpt_pkg::CFG_THROTTLE, {31'd0, throttle});
  endtask

  // Extreme field values, every operation and the lookup corner cases.
  task automatic test_directed();
    // Unknown address, then the spare op acting as a query.
    send_command(hbpt_pkg::OP_QUERY, 64'd0, 32'd0, 1'b0, 0);
    send_command(hbpt_pkg::OP_SPARE, hbpt_pkg::MAX64, hbpt_pkg::MAX32, 1'b1, 0);
    // First record on an entry, then further records.
    send_command(hbpt_pkg::OP_RECORD, 64'd0, hbpt_pkg::MAX32, 1'b0, 0);
    send_command(hbpt_pkg::OP_RECORD, 64'd0, 32'd0, 1'b1, 0);
    send_command(hbpt_pkg::OP_RECORD, 64'd0, hbpt_pkg::MAX32, 1'b0, 0);
    send_command(hbpt_pkg::OP_RECORD, hbpt_pkg::MAX64, 32'd0, 1'b0, 0);
    send_command(hbpt_pkg::OP_MARK, hbpt_pkg::MAX64, 32'd0, 1'b0, 0);
    send_command(hbpt_pkg::OP_MARK, hbpt_pkg::MAX64, 32'd0, 1'b1, 0);
    // A mark of a new address allocates an entry.
    send_command(hbpt_pkg::OP_MARK, 64'h5555_AAAA_0F0F_F0F0, hbpt_pkg::MAX32, 1'b0, 0);
    send_command(hbpt_pkg::OP_QUERY, 64'h5555_AAAA_0F0F_F0F0, 32'd0, 1'b1, 0);
    send_command(hbpt_pkg::OP_SPARE, 64'd0, 32'd0, 1'b0, 0);
    send_command(hbpt_pkg::OP_QUERY, 64'hAAAA_5555_F0F0_0F0F, 32'd0, 1'b0, 0);
  endtask

  // Threshold extremes, with and without throttling.
  task automatic test_threshold_extremes();
    set_thresholds(32'd0, 32'd0, 32'd0, 1'b1);
    for (int i = 0; i < 4; i++)
      send_command(hbpt_pkg::OP_RECORD, 64'h1234, $urandom, i[0], 0);
    write_config(hbpt_pkg::CFG_THROTTLE, 32'd0);
    send_command(hbpt_pkg::OP_QUERY, 64'h1234, 32'd0, 1'b1, 0);
    set_thresholds(hbpt_pkg::MAX32, hbpt_pkg::MAX32, hbpt_pkg::MAX32, 1'b0);
    for (int i = 0; i < 4; i++)
      send_command(hbpt_pkg::OP_RECORD, 64'h1234, $urandom, 1'b0, 0);
  endtask

  // Random traffic: a few hot blocks mixed with a wide address pool.
  task automatic test_random_traffic(int items, int idle_pct);
    logic [63:0] addr;
    logic [31:0] t;
    int pick;
    hbpt_pkg::op_e op;
    for (int i = 0; i < items; i++) begin
      addr = ($urandom_range(99) < 45) ? addr_pool[$urandom_range(3)]
                                      : addr_pool[$urandom_range(POOL - 1)];
      pick = $urandom_range(99);
      if (pick < 60) op = hbpt_pkg::OP_RECORD;
      else if (pick < 75) op = hbpt_pkg::OP_MARK;
      else if (pick < 95) op = hbpt_pkg::OP_QUERY;
      else op = hbpt_pkg::OP_SPARE;
      t = ($urandom_range(1)) ? $urandom : 32'($urandom_range(2000));
      send_command(op, addr, t, 1'($urandom_range(1)), idle_pct);
    end
  endtask

  // Stimulus sequence.
  initial begin
    start_i = 1'b0;
    op_i = hbpt_pkg::OP_QUERY;
    block_address_i = '0;
    exec_time_ns_i = '0;
    hot_cache_at_limit_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = hbpt_pkg::CFG_HOT_THR;
    cfg_data_i = '0;
    hot_thr_q = 32'd100;
    aggr_thr_q = 32'd1000;
    consec_q = 32'd3;
    throttle_q = 1'b0;
    used_q = 0;
    total_q = '0;
    hot_total_q = '0;
    marks_q = '0;
    for (int i = 0; i < POOL; i++) addr_pool[i] = {$urandom, $urandom};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_threshold_extremes();
    set_thresholds(32'd2, 32'd6, 32'd3, 1'b0);
    test_random_traffic(340, 0);
    set_thresholds(32'd0, 32'd40, 32'd0, 1'b0);
    test_random_traffic(340, 55);
    set_thresholds(32'd30, 32'd120, 32'd20, 1'b1);
    test_random_traffic(330, 0);
    set_thresholds(32'd1, 32'd3, 32'd5, 1'b0);
    test_random_traffic(330, 32);

    while (pending_profiles.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (error_count == 0)
      $display("hot_block_profile_table_top verification clean");
    else
      $display("hot_block_profile_table_top verification failed");
    $finish;
  end

endmodule
